// File: rtl/core/dop_pkg.sv
package dop_pkg;

    // parse status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_COOKIE = 2'd1;
    localparam logic [1:0] ST_BAD_LENGTH = 2'd2;
    localparam logic [1:0] ST_TRUNCATED  = 2'd3;

    // option codes of interest
    localparam logic [7:0] OPT_PAD         = 8'd0;
    localparam logic [7:0] OPT_SUBNET_MASK = 8'd1;
    localparam logic [7:0] OPT_ROUTER      = 8'd3;
    localparam logic [7:0] OPT_DNS         = 8'd6;
    localparam logic [7:0] OPT_COOKIE_SRV  = 8'd8;
    localparam logic [7:0] OPT_RESOURCE    = 8'd11;
    localparam logic [7:0] OPT_LEASE       = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE    = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID   = 8'd54;
    localparam logic [7:0] OPT_END         = 8'hFF;

    // capture slots
    localparam int CAP_NUM = 8;
    localparam logic [2:0] CAP_MASK  = 3'd0;
    localparam logic [2:0] CAP_GW    = 3'd1;
    localparam logic [2:0] CAP_DNS1  = 3'd2;
    localparam logic [2:0] CAP_DNS2  = 3'd3;
    localparam logic [2:0] CAP_AUTH  = 3'd4;
    localparam logic [2:0] CAP_FILE  = 3'd5;
    localparam logic [2:0] CAP_LEASE = 3'd6;
    localparam logic [2:0] CAP_SID   = 3'd7;

    typedef enum logic [2:0] {
        PH_DONE   = 3'd0,
        PH_COOKIE = 3'd1,
        PH_CODE   = 3'd2,
        PH_LEN    = 3'd3,
        PH_VALUE  = 3'd4
    } dop_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } dop_in_t;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [7:0]  message_type;
        logic [31:0] subnet_mask;
        logic [31:0] gateway_addr;
        logic [31:0] dns_primary;
        logic [31:0] dns_secondary;
        logic [31:0] auth_server;
        logic [31:0] file_server;
        logic [31:0] lease_seconds;
        logic [31:0] server_ident;
    } dop_out_t;

    // magic cookie 99.130.83.99
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'd99;
            2'd1:    m = 8'd130;
            2'd2:    m = 8'd83;
            default: m = 8'd99;
        endcase
        return m;
    endfunction

    // per-option length rule
    function automatic logic length_ok(input logic [7:0] code, input logic [7:0] len);
        logic ok;
        case (code) inside
            OPT_SUBNET_MASK, OPT_LEASE, OPT_SERVER_ID:
                ok = (len == 8'd4);
            OPT_MSG_TYPE:
                ok = (len == 8'd1);
            OPT_ROUTER, OPT_DNS, OPT_COOKIE_SRV, OPT_RESOURCE:
                ok = (len != 8'd0) && (len[1:0] == 2'b00);
            default:
                ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

// File: rtl/core/dhcp_option_parser.sv
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------
// input    | in_valid / in_ready  | in_beat  (dop_in_t): one vendor byte
// output   | out_valid / out_ready| out_beat (dop_out_t): status and fields
//
// one byte is taken every cycle while in_ready is high; the beat that ends the
// parse passes the input register, then the result queue, before its result appears.
// a two-slot result queue lets bytes keep flowing while one result waits.
// rst_n clears the parse state and the captured addresses to zero.
// in_ready drops only when the queue holds two results and a byte is held.
module dhcp_option_parser
    import dop_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dop_in_t  in_beat,
    output logic     out_valid,
    input  logic     out_ready,
    output dop_out_t out_beat
);

    logic     room;
    logic     push;
    dop_out_t result;

    // byte parser with capture registers
    dop_parse_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_beat  (in_beat),
        .room     (room),
        .push     (push),
        .result   (result)
    );

    // result queue
    dop_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (result),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

endmodule

// File: rtl/core/dop_parse_core.sv
module dop_parse_core
    import dop_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dop_in_t  in_beat,
    input  logic     room,
    output logic     push,
    output dop_out_t result
);

    logic        in_valid_reg;
    dop_in_t     in_beat_reg;
    logic        proc;

    dop_phase_t  phase_reg, phase_next;
    logic [1:0]  cidx_reg, cidx_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [7:0]  msg_reg, msg_next;
    logic [31:0] cap_reg [CAP_NUM];
    logic [31:0] cap_next [CAP_NUM];

    logic        fin;
    logic [1:0]  fin_status;

    // input register, freed when the queue can take a result
    assign proc     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_beat_reg <= in_beat;
        end
    end

    // one parse step per byte
    always_comb
    begin
        logic [7:0]  b;
        dop_phase_t  ph;
        b          = in_beat_reg.data_byte;
        phase_next = phase_reg;
        cidx_next  = cidx_reg;
        code_next  = code_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        msg_next   = msg_reg;
        for (int k = 0; k < CAP_NUM; k++)
        begin
            cap_next[k] = cap_reg[k];
        end
        fin        = 1'b0;
        fin_status = ST_OK;

        ph = phase_reg;
        if (in_beat_reg.first_byte)
        begin
            ph        = PH_COOKIE;
            cidx_next = 2'd0;
            msg_next  = 8'd0;
        end
        phase_next = ph;

        unique case (ph)
            PH_COOKIE:
            begin
                if (b != magic_byte(cidx_next))
                begin
                    fin        = 1'b1;
                    fin_status = ST_BAD_COOKIE;
                end
                else if (cidx_next == 2'd3)
                begin
                    phase_next = PH_CODE;
                end
                else
                begin
                    cidx_next = cidx_next + 2'd1;
                end
            end
            PH_CODE:
            begin
                if (b == OPT_PAD || b == OPT_END)
                begin
                    fin        = 1'b1;
                    fin_status = ST_OK;
                end
                else
                begin
                    code_next  = b;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (!length_ok(code_reg, b))
                begin
                    fin        = 1'b1;
                    fin_status = ST_BAD_LENGTH;
                end
                else
                begin
                    len_next   = b;
                    cnt_next   = 8'd0;
                    shift_next = 32'd0;
                    phase_next = (b == 8'd0) ? PH_CODE : PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                shift_next = {shift_reg[23:0], b};
                cnt_next   = cnt_reg + 8'd1;
                if (code_reg == OPT_MSG_TYPE && cnt_next == 8'd1)
                begin
                    msg_next = b;
                end
                if (cnt_next == 8'd4)
                begin
                    case (code_reg)
                        OPT_SUBNET_MASK: cap_next[CAP_MASK]  = shift_next;
                        OPT_ROUTER:      cap_next[CAP_GW]    = shift_next;
                        OPT_DNS:         cap_next[CAP_DNS1]  = shift_next;
                        OPT_COOKIE_SRV:  cap_next[CAP_AUTH]  = shift_next;
                        OPT_RESOURCE:    cap_next[CAP_FILE]  = shift_next;
                        OPT_LEASE:       cap_next[CAP_LEASE] = shift_next;
                        OPT_SERVER_ID:   cap_next[CAP_SID]   = shift_next;
                        default:         ;
                    endcase
                end
                if (cnt_next == 8'd8 && code_reg == OPT_DNS)
                begin
                    cap_next[CAP_DNS2] = shift_next;
                end
                if (cnt_next == len_reg)
                begin
                    phase_next = PH_CODE;
                end
            end
            default:
            begin
            end
        endcase

        // field ended before an end mark
        if (!fin && ph != PH_DONE && in_beat_reg.last_byte)
        begin
            fin        = 1'b1;
            fin_status = ST_TRUNCATED;
        end
        if (fin)
        begin
            phase_next = PH_DONE;
        end
    end

    // result assembled from the updated state
    assign push = proc && fin;

    always_comb
    begin
        result.parse_status  = fin_status;
        result.message_type  = (fin_status == ST_OK) ? msg_next : 8'd0;
        result.subnet_mask   = cap_next[CAP_MASK];
        result.gateway_addr  = cap_next[CAP_GW];
        result.dns_primary   = cap_next[CAP_DNS1];
        result.dns_secondary = cap_next[CAP_DNS2];
        result.auth_server   = cap_next[CAP_AUTH];
        result.file_server   = cap_next[CAP_FILE];
        result.lease_seconds = cap_next[CAP_LEASE];
        result.server_ident  = cap_next[CAP_SID];
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            cidx_reg  <= 2'd0;
            code_reg  <= 8'd0;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            shift_reg <= 32'd0;
            msg_reg   <= 8'd0;
            for (int k = 0; k < CAP_NUM; k++)
            begin
                cap_reg[k] <= 32'd0;
            end
        end
        else if (proc)
        begin
            phase_reg <= phase_next;
            cidx_reg  <= cidx_next;
            code_reg  <= code_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            msg_reg   <= msg_next;
            for (int k = 0; k < CAP_NUM; k++)
            begin
                cap_reg[k] <= cap_next[k];
            end
        end
    end

endmodule

// File: rtl/core/dop_out_queue.sv
module dop_out_queue
    import dop_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  dop_out_t push_beat,
    output logic     room,
    output logic     out_valid,
    input  logic     out_ready,
    output dop_out_t out_beat
);

    logic [1:0] count_reg, count_next;
    dop_out_t   head_reg;
    dop_out_t   tail_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign room      = (count_reg != 2'd2);
    assign out_beat  = head_reg;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // two result slots, head is shown on the port
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                head_reg <= tail_reg;
                if (push)
                begin
                    tail_reg <= push_beat;
                end
            end
            else if (push)
            begin
                head_reg <= push_beat;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= push_beat;
            end
            else
            begin
                tail_reg <= push_beat;
            end
        end
    end

endmodule

// File: rtl/core/dop_checker.sv
module dop_checker
    import dop_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input dop_out_t out_beat
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_beat))
        else $error("result beat changed while stalled");

    // message type only reported with a clean end
    a_msg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.parse_status != ST_OK |-> out_beat.message_type == 8'd0)
        else $error("message type set on failed parse");

    // empty result side never stalls input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // a fresh result follows an accepted byte through the input register and the queue
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a preceding byte");

endmodule

bind dhcp_option_parser dop_checker u_dop_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
);
